@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ hw/rtl/md5_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg: shared types and constants
// Initial chaining values, round constants, rotation amounts and the
// queue entry passed from intake to the compression engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C   = 32'h98BADCFE;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [31:0] PAD_WORD = 32'd128;
    localparam int          QDEPTH   = 4;
    localparam int          QAW      = $clog2(QDEPTH);

    typedef struct packed {
        logic [31:0] word;
        logic        fin;   // last padded word of the message
    } t_qent;

    function automatic logic [31:0] f_kconst(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hD76AA478;  6'd1: k = 32'hE8C7B756;
                6'd2: k = 32'h242070DB;  6'd3: k = 32'hC1BDCEEE;
                6'd4: k = 32'hF57C0FAF;  6'd5: k = 32'h4787C62A;
                6'd6: k = 32'hA8304613;  6'd7: k = 32'hFD469501;
                6'd8: k = 32'h698098D8;  6'd9: k = 32'h8B44F7AF;
                6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
                6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
                6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
                6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
                6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
                6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
                6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
                6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
                6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
                6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
                6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
                6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
                6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
                6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
                6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
                6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
                6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
                6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
                6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
                6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
                6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
                6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
                6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
                6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
                6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
                6'd62: k = 32'h2AD7D2BB; 6'd63: k = 32'hEB86D391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] f_rot(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
                4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
                4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'hA: s = 5'd16; 4'hB: s = 5'd23;
                4'hC: s = 5'd6;  4'hD: s = 5'd10; 4'hE: s = 5'd15; 4'hF: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/md5_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_in_if / md5_out_if: valid/ready channels
// Message word channel and digest word channel.
// ----------------------------------------------------------------------------
interface md5_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        last_word;
    modport source (output valid, msg_word, byte_count, last_word, input ready);
    modport sink   (input valid, msg_word, byte_count, last_word, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
    modport source (output valid, digest_word, word_index, digest_last, input ready);
    modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/md5_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_front: intake and padding
// Accepts message words, applies byte masking and the pad byte, and issues
// zero fill and length words into the word queue, one word a cycle while the queue is not full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module md5_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    md5_in_if.sink             s_in,
    output md5_pkg::t_qent     o_q_data,
    output logic               o_q_push,
    input  wire logic          i_q_full
);
    import md5_pkg::*;

    localparam logic [1:0] ST_TAKE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;   // pad byte word after a full last word
    localparam logic [1:0] ST_FILL = 2'd2;   // zero fill up to the length
    localparam logic [1:0] ST_LEN  = 2'd3;   // length low then high word

    logic [1:0]  r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic        r_hi, n_hi;
    logic [2:0]  w_cnt;
    logic [31:0] w_mask;
    logic        w_acc;

    assign s_in.ready = (r_state == ST_TAKE) && !i_q_full;
    assign w_acc      = s_in.valid && s_in.ready;
    assign w_cnt      = (s_in.byte_count > 3'd4) ? 3'd4 : s_in.byte_count;

    always_comb begin
        case (w_cnt)
            3'd0:    w_mask = 32'h0000_0000;
            3'd1:    w_mask = 32'h0000_00FF;
            3'd2:    w_mask = 32'h0000_FFFF;
            3'd3:    w_mask = 32'h00FF_FFFF;
            default: w_mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_len    = r_len;
        n_hi     = r_hi;
        o_q_push = 1'b0;
        o_q_data = '{word: 32'h0, fin: 1'b0};
        case (r_state)
            ST_TAKE: begin
                if (w_acc) begin
                    o_q_push = 1'b1;
                    n_pos    = r_pos + 4'd1;
                    if (!s_in.last_word) begin
                        o_q_data.word = s_in.msg_word;
                        n_len         = r_len + 32'd32;
                    end else begin
                        n_len = r_len + {26'h0, w_cnt, 3'b000};
                        if (w_cnt == 3'd4) begin
                            o_q_data.word = s_in.msg_word;
                            n_state       = ST_PAD;
                        end else begin
                            o_q_data.word = (s_in.msg_word & w_mask) |
                                            (PAD_WORD << {w_cnt[1:0], 3'b000});
                            n_state = (r_pos + 4'd1 == 4'd14) ? ST_LEN : ST_FILL;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (!i_q_full) begin
                    o_q_push      = 1'b1;
                    o_q_data.word = PAD_WORD;
                    n_pos         = r_pos + 4'd1;
                    n_state       = (r_pos + 4'd1 == 4'd14) ? ST_LEN : ST_FILL;
                end
            end
            ST_FILL: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_pos    = r_pos + 4'd1;
                    if (r_pos + 4'd1 == 4'd14) begin
                        n_state = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_pos    = r_pos + 4'd1;
                    if (!r_hi) begin
                        o_q_data.word = r_len;
                        n_hi          = 1'b1;
                    end else begin
                        o_q_data.fin = 1'b1;
                        n_hi         = 1'b0;
                        n_len        = 32'h0;
                        n_state      = ST_TAKE;
                    end
                end
            end
            default: n_state = ST_TAKE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_TAKE;
            r_pos   <= 4'd0;
            r_len   <= 32'h0;
            r_hi    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_hi    <= n_hi;
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, o_q_push && i_q_full, "push into full queue")
    `ASSERT_CLK(a_len_pos, i_clk, i_rst_n, (r_state == ST_LEN && !r_hi) |-> (r_pos == 4'd14), "length word misplaced")
    `ASSERT_CLK(a_fin_pos, i_clk, i_rst_n, (o_q_push && o_q_data.fin) |-> (r_pos == 4'd15), "final word misplaced")

endmodule
`default_nettype wire

@@ hw/rtl/md5_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_fifo: word queue
// Short register queue between intake and compression.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module md5_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire md5_pkg::t_qent i_data,
    input  wire logic          i_push,
    output logic               o_full,
    output md5_pkg::t_qent     o_data,
    output logic               o_empty,
    input  wire logic          i_pop
);
    import md5_pkg::*;

    t_qent        r_mem [QDEPTH];
    logic [QAW:0] r_wp, r_rp;

    assign o_full  = (r_wp[QAW] != r_rp[QAW]) && (r_wp[QAW-1:0] == r_rp[QAW-1:0]);
    assign o_empty = (r_wp == r_rp);
    assign o_data  = r_mem[r_rp[QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp[QAW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end

    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && o_empty, "pop from empty queue")
    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_CLK(a_fill, i_clk, i_rst_n, (r_wp - r_rp) <= (QAW+1)'(QDEPTH), "occupancy overflow")

endmodule
`default_nettype wire

@@ hw/rtl/md5_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_core: block buffer and compression
// Loads 16 words, runs 64 rounds one per cycle, updates the chaining values
// and, after a final block, sends four digest words and reinitialises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module md5_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire md5_pkg::t_qent i_q_data,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    md5_out_if.source          m_out
);
    import md5_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [31:0] r_buf [16];
    logic [1:0]  r_state;
    logic [3:0]  r_wpos;
    logic [5:0]  r_rnd;
    logic        r_fin;
    logic [1:0]  r_oidx;
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] w_f, w_sum, w_rot, w_m;
    logic [3:0]  w_g;
    logic [4:0]  w_s;
    logic [63:0] w_dbl;

    assign o_q_pop = (r_state == ST_LOAD) && !i_q_empty;

    always_comb begin
        case (r_rnd[5:4])
            2'd0: begin
                w_f = (r_b & r_c) | (~r_b & r_d);
                w_g = r_rnd[3:0];
            end
            2'd1: begin
                w_f = (r_b & r_d) | (r_c & ~r_d);
                w_g = 4'(r_rnd[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                w_f = r_b ^ r_c ^ r_d;
                w_g = 4'(r_rnd[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                w_f = r_c ^ (r_b | ~r_d);
                w_g = 4'(r_rnd[3:0] * 4'd7);
            end
        endcase
    end

    assign w_m   = r_buf[w_g];
    assign w_s   = f_rot(r_rnd);
    assign w_sum = r_a + w_f + f_kconst(r_rnd) + w_m;
    assign w_dbl = {w_sum, w_sum} << w_s;
    assign w_rot = w_dbl[63:32];

    assign m_out.valid       = (r_state == ST_OUT);
    assign m_out.digest_word = r_h[r_oidx];
    assign m_out.word_index  = r_oidx;
    assign m_out.digest_last = (r_oidx == 2'd3);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_buf[r_wpos] <= i_q_data.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_wpos  <= 4'd0;
            r_rnd   <= 6'd0;
            r_fin   <= 1'b0;
            r_oidx  <= 2'd0;
            r_h[0]  <= INIT_A;
            r_h[1]  <= INIT_B;
            r_h[2]  <= INIT_C;
            r_h[3]  <= INIT_D;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (o_q_pop) begin
                        r_wpos <= r_wpos + 4'd1;
                        if (r_wpos == 4'd15) begin
                            r_fin   <= i_q_data.fin;
                            r_state <= ST_RUN;
                            r_rnd   <= 6'd0;
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                        end
                    end
                end
                ST_RUN: begin
                    r_a   <= r_d;
                    r_d   <= r_c;
                    r_c   <= r_b;
                    r_b   <= r_b + w_rot;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_oidx  <= 2'd0;
                    r_state <= r_fin ? ST_OUT : ST_LOAD;
                end
                ST_OUT: begin
                    if (m_out.ready) begin
                        r_oidx <= r_oidx + 2'd1;
                        if (r_oidx == 2'd3) begin
                            r_state <= ST_LOAD;
                            r_h[0]  <= INIT_A;
                            r_h[1]  <= INIT_B;
                            r_h[2]  <= INIT_C;
                            r_h[3]  <= INIT_D;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    `ASSERT_CLK(a_run_len, i_clk, i_rst_n, (r_state == ST_RUN && r_rnd == 6'd63) |=> (r_state == ST_ADD), "round count slip")
    `ASSERT_NEVER(a_pop_run, i_clk, i_rst_n, o_q_pop && r_state != ST_LOAD, "load outside intake")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(r_oidx)), "digest request dropped")

endmodule
`default_nettype wire

@@ hw/rtl/md5_digest_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_digest_unit: streaming MD5 digest
// Top level joining intake, word queue and compression engine.
// ----------------------------------------------------------------------------
// Use: message words enter on s_in (msg_word little-endian, byte_count valid
// bytes on the last word, last_word ends the message). After a last word the
// digest leaves on m_out as four requests, A to D, digest_last on D.
// The compression engine loads a block of 16 words from the queue, runs
// its 64 rounds at one round a cycle, then adds into the chaining values;
// the four-entry queue lets intake run ahead by four words while the
// engine runs rounds. A last word adds padding words at one a cycle while
// the queue has room; the digest follows the rounds and chaining add of
// the final block.
// Reset clears the chaining values to the MD5 initial values and empties the
// queue. If the receiver stalls the digest, the word holds, the engine waits
// and intake stops once the queue fills.
// ----------------------------------------------------------------------------
module md5_digest_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    md5_in_if.sink    s_in,
    md5_out_if.source m_out
);
    import md5_pkg::*;

    t_qent w_fd, w_qd;
    logic  w_push, w_full, w_empty, w_pop;

    md5_front u_front (
        .i_clk, .i_rst_n, .s_in,
        .o_q_data(w_fd), .o_q_push(w_push), .i_q_full(w_full)
    );

    md5_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_data(w_fd), .i_push(w_push), .o_full(w_full),
        .o_data(w_qd), .o_empty(w_empty), .i_pop(w_pop)
    );

    md5_core u_core (
        .i_clk, .i_rst_n,
        .i_q_data(w_qd), .i_q_empty(w_empty), .o_q_pop(w_pop), .m_out
    );

endmodule
`default_nettype wire
